// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros shared by the monitor modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define V86_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define V86_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/v86mon_pkg.sv -----
// ---------------------------------------------------------------------------
// v86mon_pkg
// types, codes and helpers of the v86 sensitive instruction monitor
// ---------------------------------------------------------------------------
package v86mon_pkg;

   localparam int MaxResults = 4;
   localparam int CountWidth = $clog2(MaxResults + 1);

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_DATA  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SZ_BYTE  = 2'd0,
      SZ_WORD  = 2'd1,
      SZ_DWORD = 2'd2
   } size_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EXIT_IRET = 3'd1,
      ST_EXIT_POPF = 3'd2,
      ST_IO        = 3'd3,
      ST_UNKNOWN   = 3'd4,
      ST_NOT_V86   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_OPC     = 3'd1,
      PH_VECNUM  = 3'd2,
      PH_VEC     = 3'd3,
      PH_IRET_IP = 3'd4,
      PH_IRET_CS = 3'd5,
      PH_IRET_FL = 3'd6,
      PH_POPF    = 3'd7
   } phase_type;

   localparam logic [2:0] REG_CS     = 3'd0;
   localparam logic [2:0] REG_EIP    = 3'd1;
   localparam logic [2:0] REG_SS     = 3'd2;
   localparam logic [2:0] REG_ESP    = 3'd3;
   localparam logic [2:0] REG_EFLAGS = 3'd4;

   localparam logic [1:0] EXIT_NONE = 2'd0;
   localparam logic [1:0] EXIT_IRET = 2'd1;
   localparam logic [1:0] EXIT_POPF = 2'd2;

   localparam int IfBit  = 9;
   localparam int VmBit  = 17;
   localparam int Op32Bit = 6;

   localparam logic [7:0] OP_ES   = 8'h26;
   localparam logic [7:0] OP_CS   = 8'h2e;
   localparam logic [7:0] OP_SS   = 8'h36;
   localparam logic [7:0] OP_DS   = 8'h3e;
   localparam logic [7:0] OP_FS   = 8'h64;
   localparam logic [7:0] OP_GS   = 8'h65;
   localparam logic [7:0] OP_OPSZ = 8'h66;
   localparam logic [7:0] OP_ADSZ = 8'h67;
   localparam logic [7:0] OP_LOCK = 8'hf0;
   localparam logic [7:0] OP_REPN = 8'hf2;
   localparam logic [7:0] OP_REP  = 8'hf3;
   localparam logic [7:0] OP_INT  = 8'hcd;
   localparam logic [7:0] OP_IRET = 8'hcf;
   localparam logic [7:0] OP_PUSHF = 8'h9c;
   localparam logic [7:0] OP_POPF = 8'h9d;
   localparam logic [7:0] OP_CLI  = 8'hfa;
   localparam logic [7:0] OP_STI  = 8'hfb;

   localparam logic [31:0] IRET_LIM32 = 32'h0000_0ff4;
   localparam logic [31:0] IRET_LIM16 = 32'h0000_0ffa;
   localparam logic [31:0] POPF_LIM32 = 32'h0000_0ffc;
   localparam logic [31:0] POPF_LIM16 = 32'h0000_0ffe;

   typedef struct packed {
      kind_type    kind;
      size_type    size_code;
      logic [20:0] address;
      logic [31:0] write_data;
      logic [31:0] reg_value;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [CountWidth-1:0]        count;
      rsp_type [MaxResults-1:0]     slot;
   } bundle_type;

   function automatic logic [20:0] lin(input logic [15:0] seg, input logic [15:0] off);
      lin = {1'b0, seg, 4'b0000} + {5'b00000, off};
   endfunction

   function automatic rsp_type mk_read(input size_type sz, input logic [20:0] addr);
      rsp_type r;
      r = '0;
      r.kind = KIND_READ;
      r.size_code = sz;
      r.address = addr;
      r.status = ST_OK;
      mk_read = r;
   endfunction

   function automatic rsp_type mk_write(input size_type sz, input logic [20:0] addr,
                                        input logic [31:0] wd);
      rsp_type r;
      r = '0;
      r.kind = KIND_WRITE;
      r.size_code = sz;
      r.address = addr;
      r.write_data = wd;
      r.status = ST_OK;
      mk_write = r;
   endfunction

   function automatic rsp_type mk_done(input status_type st, input logic [31:0] rv);
      rsp_type r;
      r = '0;
      r.kind = KIND_DONE;
      r.size_code = SZ_BYTE;
      r.reg_value = rv;
      r.status = st;
      mk_done = r;
   endfunction

   // prefix byte to its mask bit, zero for anything else
   function automatic logic [10:0] prefix_bit(input logic [7:0] b);
      logic [10:0] m;
      m = '0;
      unique case (b)
         OP_ES:   m = 11'h001;
         OP_CS:   m = 11'h002;
         OP_SS:   m = 11'h004;
         OP_DS:   m = 11'h008;
         OP_FS:   m = 11'h010;
         OP_GS:   m = 11'h020;
         OP_OPSZ: m = 11'h040;
         OP_ADSZ: m = 11'h080;
         OP_LOCK: m = 11'h100;
         OP_REPN: m = 11'h200;
         OP_REP:  m = 11'h400;
         default: m = '0;
      endcase
      prefix_bit = m;
   endfunction

   // in, out, ins and outs opcodes
   function automatic logic is_io(input logic [7:0] b);
      is_io = (b[7:2] == 6'b111001) || (b[7:2] == 6'b011011) || (b[7:2] == 6'b111011);
   endfunction

endpackage

// ----- hdl/v86mon_core.sv -----
// ---------------------------------------------------------------------------
// v86mon_core
// guest register file, handler phase and decode of one incoming word into
// the full set of results it causes
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module v86mon_core
   import v86mon_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  cmd_type     cmd,
   input  logic [31:0] data,
   input  logic [2:0]  reg_index,
   output bundle_type  bundle
);

   logic [15:0] cs_ff, cs_in, ss_ff, ss_in;
   logic [31:0] eip_ff, eip_in, esp_ff, esp_in, eflags_ff, eflags_in;
   logic [10:0] prefix_ff, prefix_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  pend_ff, pend_in;

   logic        op32;
   logic [7:0]  opc;
   logic [10:0] pbit;
   size_type    pop_sz;
   logic [15:0] pop_step;
   logic [15:0] esp1, esp2, esp3;
   logic [20:0] pop_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff     <= '0;
         eip_ff    <= '0;
         ss_ff     <= '0;
         esp_ff    <= '0;
         eflags_ff <= '0;
         prefix_ff <= '0;
         phase_ff  <= PH_IDLE;
         pend_ff   <= EXIT_NONE;
      end else if (accept) begin
         cs_ff     <= cs_in;
         eip_ff    <= eip_in;
         ss_ff     <= ss_in;
         esp_ff    <= esp_in;
         eflags_ff <= eflags_in;
         prefix_ff <= prefix_in;
         phase_ff  <= phase_in;
         pend_ff   <= pend_in;
      end
   end

   assign op32     = prefix_ff[Op32Bit];
   assign opc      = data[7:0];
   assign pbit     = prefix_bit(opc);
   assign pop_sz   = op32 ? SZ_DWORD : SZ_WORD;
   assign pop_step = op32 ? 16'd4 : 16'd2;
   assign pop_addr = lin(ss_ff, esp_ff[15:0]);
   assign esp1     = esp_ff[15:0] - 16'd2;
   assign esp2     = esp_ff[15:0] - 16'd4;
   assign esp3     = esp_ff[15:0] - 16'd6;

   always_comb begin
      cs_in     = cs_ff;
      eip_in    = eip_ff;
      ss_in     = ss_ff;
      esp_in    = esp_ff;
      eflags_in = eflags_ff;
      prefix_in = prefix_ff;
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      bundle    = '0;

      unique case (cmd)
         CMD_START: begin
            prefix_in = '0;
            pend_in   = EXIT_NONE;
            if (!eflags_ff[VmBit]) begin
               bundle.slot[0] = mk_done(ST_NOT_V86, 32'd0);
               bundle.count   = CountWidth'(1);
               phase_in       = PH_IDLE;
            end else begin
               bundle.slot[0] = mk_read(SZ_BYTE, lin(cs_ff, eip_ff[15:0]));
               bundle.count   = CountWidth'(1);
               eip_in         = eip_ff + 32'd1;
               phase_in       = PH_OPC;
            end
         end

         CMD_WRITE: begin
            unique case (reg_index)
               REG_CS:     cs_in     = data[15:0];
               REG_EIP:    eip_in    = data;
               REG_SS:     ss_in     = data[15:0];
               REG_ESP:    esp_in    = data;
               REG_EFLAGS: eflags_in = data;
               default:    ;
            endcase
         end

         CMD_READ: begin
            bundle.count = CountWidth'(1);
            unique case (reg_index)
               REG_CS:     bundle.slot[0] = mk_done(ST_OK, {16'd0, cs_ff});
               REG_EIP:    bundle.slot[0] = mk_done(ST_OK, eip_ff);
               REG_SS:     bundle.slot[0] = mk_done(ST_OK, {16'd0, ss_ff});
               REG_ESP:    bundle.slot[0] = mk_done(ST_OK, esp_ff);
               REG_EFLAGS: bundle.slot[0] = mk_done(ST_OK, eflags_ff);
               default:    bundle.slot[0] = mk_done(ST_OK, 32'd0);
            endcase
         end

         CMD_DATA: begin
            unique case (phase_ff)
               PH_OPC: begin
                  bundle.count = CountWidth'(1);
                  if (pbit != '0) begin
                     prefix_in      = prefix_ff | pbit;
                     bundle.slot[0] = mk_read(SZ_BYTE, lin(cs_ff, eip_ff[15:0]));
                     eip_in         = eip_ff + 32'd1;
                  end else begin
                     priority if (opc == OP_INT) begin
                        phase_in       = PH_VECNUM;
                        bundle.slot[0] = mk_read(SZ_BYTE, lin(cs_ff, eip_ff[15:0]));
                        eip_in         = eip_ff + 32'd1;
                     end else if (opc == OP_IRET || opc == OP_POPF) begin
                        // exit check looks at the full esp before the first pop
                        if (opc == OP_IRET) begin
                           if (esp_ff > (op32 ? IRET_LIM32 : IRET_LIM16)) pend_in = EXIT_IRET;
                           phase_in = PH_IRET_IP;
                        end else begin
                           if (esp_ff > (op32 ? POPF_LIM32 : POPF_LIM16)) pend_in = EXIT_POPF;
                           phase_in = PH_POPF;
                        end
                        bundle.slot[0] = mk_read(pop_sz, pop_addr);
                        esp_in         = {16'd0, esp_ff[15:0] + pop_step};
                     end else if (opc == OP_PUSHF) begin
                        if (op32) begin
                           esp_in         = {16'd0, esp2};
                           bundle.slot[0] = mk_write(SZ_DWORD, lin(ss_ff, esp2), eflags_ff);
                        end else begin
                           esp_in         = {16'd0, esp1};
                           bundle.slot[0] = mk_write(SZ_WORD, lin(ss_ff, esp1),
                                                     {16'd0, eflags_ff[15:0]});
                        end
                        bundle.slot[1] = mk_done(ST_OK, 32'd0);
                        bundle.count   = CountWidth'(2);
                        phase_in       = PH_IDLE;
                        pend_in        = EXIT_NONE;
                     end else if (opc == OP_CLI || opc == OP_STI) begin
                        eflags_in[IfBit] = (opc == OP_STI);
                        bundle.slot[0]   = mk_done(ST_OK, 32'd0);
                        phase_in         = PH_IDLE;
                        pend_in          = EXIT_NONE;
                     end else begin
                        bundle.slot[0] = mk_done(is_io(opc) ? ST_IO : ST_UNKNOWN, 32'd0);
                        phase_in       = PH_IDLE;
                        pend_in        = EXIT_NONE;
                     end
                  end
               end

               PH_VECNUM: begin
                  // flags, cs and ip always go out as words
                  bundle.slot[0] = mk_write(SZ_WORD, lin(ss_ff, esp1),
                                            {16'd0, eflags_ff[15:0]});
                  bundle.slot[1] = mk_write(SZ_WORD, lin(ss_ff, esp2), {16'd0, cs_ff});
                  bundle.slot[2] = mk_write(SZ_WORD, lin(ss_ff, esp3),
                                            {16'd0, eip_ff[15:0]});
                  bundle.slot[3] = mk_read(SZ_DWORD, {11'd0, opc, 2'b00});
                  bundle.count   = CountWidth'(4);
                  esp_in         = {16'd0, esp3};
                  phase_in       = PH_VEC;
               end

               PH_VEC: begin
                  eip_in         = {16'd0, data[15:0]};
                  cs_in          = data[31:16];
                  bundle.slot[0] = mk_done(ST_OK, 32'd0);
                  bundle.count   = CountWidth'(1);
                  phase_in       = PH_IDLE;
                  pend_in        = EXIT_NONE;
               end

               PH_IRET_IP, PH_IRET_CS: begin
                  if (phase_ff == PH_IRET_IP) begin
                     eip_in   = op32 ? data : {16'd0, data[15:0]};
                     phase_in = PH_IRET_CS;
                  end else begin
                     cs_in    = data[15:0];
                     phase_in = PH_IRET_FL;
                  end
                  bundle.slot[0] = mk_read(pop_sz, pop_addr);
                  bundle.count   = CountWidth'(1);
                  esp_in         = {16'd0, esp_ff[15:0] + pop_step};
               end

               PH_IRET_FL, PH_POPF: begin
                  eflags_in      = op32 ? data : {eflags_ff[31:16], data[15:0]};
                  bundle.slot[0] = mk_done(status_type'({1'b0, pend_ff}), 32'd0);
                  bundle.count   = CountWidth'(1);
                  phase_in       = PH_IDLE;
                  pend_in        = EXIT_NONE;
               end

               default: ;
            endcase
         end

         default: ;
      endcase
   end

   `V86_ASSERT(a_idle_no_exit, clock, reset, (phase_ff == PH_IDLE) |-> (pend_ff == EXIT_NONE), "exit status pending while idle")
   `V86_ASSERT(a_vec_after_int, clock, reset, (phase_ff == PH_VEC) |-> ($past(phase_ff) == PH_VECNUM || $past(phase_ff) == PH_VEC), "vector phase entered without vector number")

endmodule

// ----- hdl/v86mon_out.sv -----
// ---------------------------------------------------------------------------
// v86mon_out
// result register: holds the results of one accepted word and hands them
// out one per handshake, oldest first
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module v86mon_out
   import v86mon_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  bundle_type bundle,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_rsp,
   output logic       out_last
);

   logic [CountWidth-1:0]    cnt_ff;
   rsp_type [MaxResults-1:0] slot_ff;
   logic                     fire_in;
   logic                     fire_out;

   assign out_valid = (cnt_ff != '0);
   assign out_last  = (cnt_ff == CountWidth'(1));
   assign out_rsp   = slot_ff[0];
   assign fire_out  = out_valid && out_ready;
   // take the next word when empty or while the last pending result leaves
   assign in_ready  = !out_valid || (out_last && out_ready);
   assign fire_in   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (fire_in) begin
         cnt_ff <= bundle.count;
      end else if (fire_out) begin
         cnt_ff <= cnt_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (fire_in) begin
         slot_ff <= bundle.slot;
      end else if (fire_out) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

   `V86_ASSERT(a_cnt_range, clock, reset, (cnt_ff <= CountWidth'(MaxResults)), "result count out of range")
   `V86_ASSERT(a_empty_ready, clock, reset, (cnt_ff == '0) |-> in_ready, "empty result register refuses input")
   `V86_ASSERT(a_more_follow, clock, reset, (fire_out && !fire_in && cnt_ff > CountWidth'(1)) |=> (out_valid && cnt_ff == $past(cnt_ff) - CountWidth'(1)), "result dropped")

endmodule

// ----- hdl/v86_sensitive_instruction_monitor.sv -----
// ---------------------------------------------------------------------------
// v86_sensitive_instruction_monitor
// emulates one faulting virtual-8086 instruction against held guest state
// ---------------------------------------------------------------------------
// usage:
//   req channel carries commands: start handler, memory read data, guest
//   register write and guest register read. rsp channel carries memory read
//   and write requests and done words; tlast marks the last word caused by
//   one request word.
//   latency: the first result of a request word is valid in the cycle after
//   it is accepted.
//   throughput: one request word per cycle while each causes at most one
//   result and rsp_tready is high; a word with n results (int n gives four)
//   holds the request side as the result register drains one per handshake.
//   register writes and read data with nothing pending give no result.
//   reset: guest registers, prefix mask and exit status clear, the handler
//   goes idle and the result register empties.
//   stall: while rsp_tready is low the pending result holds and req_tready
//   stays low as long as the result register holds any word.
// ---------------------------------------------------------------------------
module v86_sensitive_instruction_monitor
   import v86mon_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // data
   input  logic [4:0]  req_tuser,  // cmd, reg_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // size_code, address, write_data, reg_value, status
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast
);

   bundle_type bundle;
   rsp_type    rsp;
   logic       accept;

   assign accept = req_tvalid && req_tready;

   v86mon_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (cmd_type'(req_tuser[1:0])),
      .data      (req_tdata),
      .reg_index (req_tuser[4:2]),
      .bundle    (bundle)
   );

   v86mon_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .bundle    (bundle),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {6'd0, rsp.status, rsp.reg_value, rsp.write_data,
                       rsp.address, rsp.size_code};

endmodule
